>>> hdl/dvc_pkg.sv
// Shared constants and controller/datapath interface types for the duplicate value counter.
`default_nettype none
package dvc_pkg;

	localparam int MAX_ITEMS_DEF   = 64;
	localparam int VALUE_RANGE_DEF = 128;
	localparam int VALUE_W         = 7;
	localparam int OCC_W           = 7;

	typedef struct packed {
		logic load_en;
		logic scan_issue;
		logic clr_step;
		logic finish;
	} dvc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_end;
		logic pipe_busy;
	} dvc_sts_t;

endpackage
`default_nettype wire

>>> hdl/dvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hdl/dvc_ctrl.sv
// Controller state machine: histogram clear, load, scan, drain and final report.
`default_nettype none
module dvc_ctrl
	import dvc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     final_item,
	output logic          busy,
	output dvc_cmd_t      cmd,
	input  wire dvc_sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start && final_item) begin
						state_q <= ST_SCAN;
						busy_q  <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (sts.scan_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_CLEAR;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	assign busy           = busy_q;
	assign cmd.load_en    = start && !busy_q;
	assign cmd.scan_issue = (state_q == ST_SCAN) && !sts.scan_end;
	assign cmd.clr_step   = (state_q == ST_CLEAR);
	assign cmd.finish     = (state_q == ST_DONE);

endmodule
`default_nettype wire

>>> hdl/dvc_datapath.sv
// Datapath: sequence store, occurrence histogram with read-modify-write, and report registers.
`default_nettype none
module dvc_datapath
	import dvc_pkg::*;
#(
	parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
	parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dvc_cmd_t           cmd,
	output dvc_sts_t                sts,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    result_valid,
	output logic      [VALUE_W-1:0] dup_value,
	output logic      [OCC_W-1:0]   occurrences,
	output logic                    found,
	output logic                    last_report
);

	localparam int SAW = $clog2(MAX_ITEMS);
	localparam int HAW = $clog2(VALUE_RANGE);
	localparam int CW  = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0]          items_q;
	logic [CW-1:0]          k_q;
	logic [HAW-1:0]         clr_q;
	logic                   seq_v_s1;
	logic                   hist_v_s1;
	logic                   hist_clr_s1;
	logic [HAW-1:0]         hist_addr_s1;
	logic [VALUE_W-1:0]     hist_val_s1;
	logic                   fwd_v_q;
	logic [HAW-1:0]         fwd_addr_q;
	logic [CW-1:0]          fwd_data_q;
	logic                   pend_v_q;
	logic [VALUE_W-1:0]     pend_val_q;
	logic [CW-1:0]          pend_cnt_q;
	logic                   strobe_q;
	logic [VALUE_W-1:0]     res_val_q;
	logic [CW-1:0]          res_cnt_q;
	logic                   res_found_q;
	logic                   res_last_q;

	logic                   in_range;
	logic                   not_full;
	logic                   store;
	logic [VALUE_W-1:0]     seq_rdata;
	logic [VALUE_W-1:0]     sel_val;
	logic [VALUE_W+HAW-1:0] sel_ext;
	logic [HAW-1:0]         hist_raddr;
	logic [CW-1:0]          hist_rdata;
	logic [CW-1:0]          cnt;
	logic [CW-1:0]          hist_upd;
	logic                   hist_we;
	logic [HAW-1:0]         hist_waddr;
	logic [CW-1:0]          hist_wdata;
	logic                   rep_ev;
	logic [OCC_W+CW-1:0]    occ_ext;

	assign in_range = 32'(value) < VALUE_RANGE;
	assign not_full = items_q < CW'(MAX_ITEMS);
	assign store    = cmd.load_en && in_range && not_full;

	dvc_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_ITEMS)
	) u_seq_ram (
		.clk   (clk),
		.we    (store),
		.waddr (items_q[SAW-1:0]),
		.wdata (value),
		.raddr (k_q[SAW-1:0]),
		.rdata (seq_rdata)
	);

	assign sel_val    = seq_v_s1 ? seq_rdata : value;
	assign sel_ext    = {{HAW{1'b0}}, sel_val};
	assign hist_raddr = sel_ext[HAW-1:0];

	assign cnt        = (fwd_v_q && (fwd_addr_q == hist_addr_s1)) ? fwd_data_q : hist_rdata;
	assign hist_upd   = hist_clr_s1 ? '0 : cnt + CW'(1);
	assign hist_we    = cmd.clr_step || hist_v_s1;
	assign hist_waddr = cmd.clr_step ? clr_q : hist_addr_s1;
	assign hist_wdata = cmd.clr_step ? '0 : hist_upd;
	assign rep_ev     = hist_v_s1 && hist_clr_s1 && (cnt > CW'(1));

	dvc_ram #(
		.WIDTH (CW),
		.DEPTH (VALUE_RANGE)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q     <= '0;
			k_q         <= '0;
			clr_q       <= '0;
			seq_v_s1    <= 1'b0;
			hist_v_s1   <= 1'b0;
			hist_clr_s1 <= 1'b0;
			fwd_v_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			seq_v_s1    <= cmd.scan_issue;
			hist_v_s1   <= store || seq_v_s1;
			hist_clr_s1 <= seq_v_s1;
			fwd_v_q     <= hist_v_s1;
			strobe_q    <= cmd.finish || (rep_ev && pend_v_q);
			if (cmd.clr_step) begin
				clr_q <= clr_q + HAW'(1);
			end
			if (store) begin
				items_q <= items_q + CW'(1);
			end
			if (cmd.scan_issue) begin
				k_q <= k_q + CW'(1);
			end
			if (cmd.finish) begin
				items_q  <= '0;
				k_q      <= '0;
				pend_v_q <= 1'b0;
			end else if (rep_ev) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		hist_addr_s1 <= hist_raddr;
		hist_val_s1  <= sel_val;
		fwd_addr_q   <= hist_addr_s1;
		fwd_data_q   <= hist_upd;
		if (rep_ev) begin
			pend_val_q <= hist_val_s1;
			pend_cnt_q <= cnt;
		end
		if (cmd.finish) begin
			res_val_q   <= pend_v_q ? pend_val_q : '0;
			res_cnt_q   <= pend_v_q ? pend_cnt_q : '0;
			res_found_q <= pend_v_q;
			res_last_q  <= 1'b1;
		end else if (rep_ev && pend_v_q) begin
			res_val_q   <= pend_val_q;
			res_cnt_q   <= pend_cnt_q;
			res_found_q <= 1'b1;
			res_last_q  <= 1'b0;
		end
	end

	assign occ_ext      = {{OCC_W{1'b0}}, res_cnt_q};
	assign result_valid = strobe_q;
	assign dup_value    = res_val_q;
	assign occurrences  = occ_ext[OCC_W-1:0];
	assign found        = res_found_q;
	assign last_report  = res_last_q;

	assign sts.clr_last  = (clr_q == HAW'(VALUE_RANGE - 1));
	assign sts.scan_end  = (k_q == items_q);
	assign sts.pipe_busy = seq_v_s1 || hist_v_s1;

`ifndef ASSERT_OFF
	a_notfound_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> last_report)
		else $error("not-found result without last_report");
	a_found_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && found |-> occurrences > OCC_W'(1))
		else $error("reported value does not repeat");
	a_items_bound: assert property (@(posedge clk) disable iff (!arst_n)
		items_q <= CW'(MAX_ITEMS))
		else $error("item count beyond store depth");
	a_scan_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_issue |-> k_q < items_q)
		else $error("scan read beyond loaded items");
	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		seq_v_s1 |-> !store)
		else $error("transaction accepted during scan");
`endif

endmodule
`default_nettype wire

>>> hdl/duplicate_value_counter_unit.sv
// Top level of the duplicate value counter: controller and datapath.
`default_nettype none
// Values of a set are taken one per cycle (start while busy is low); the transaction with
// final_item high ends the set. Each value below VALUE_RANGE is appended to a sequence RAM
// of MAX_ITEMS entries while it has room, and its histogram entry is incremented by a
// read-modify-write with a forwarding register, so loading runs at one value per cycle.
// After the final value busy stays high while the sequence RAM is read back one entry per
// cycle; each histogram entry is reported on its first visit and cleared in the same pass.
// Each value seen more than once gives one result in arrival order; a set with no repeat
// gives one result with found low. last_report marks the final result of a set, which
// comes in the same cycle as busy falls. Every result is on the outputs for one cycle with
// result_valid high and cannot be held off. After reset busy stays high while the histogram
// RAM is cleared one entry per cycle.
module duplicate_value_counter_unit
	import dvc_pkg::*;
#(
	parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
	parameter int VALUE_RANGE = VALUE_RANGE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [VALUE_W-1:0] value,
	input  wire logic               final_item,
	output logic                    result_valid,
	output logic      [VALUE_W-1:0] dup_value,
	output logic      [OCC_W-1:0]   occurrences,
	output logic                    found,
	output logic                    last_report
);

	dvc_cmd_t cmd;
	dvc_sts_t sts;

	dvc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.final_item (final_item),
		.busy       (busy),
		.cmd        (cmd),
		.sts        (sts)
	);

	dvc_datapath #(
		.MAX_ITEMS   (MAX_ITEMS),
		.VALUE_RANGE (VALUE_RANGE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.result_valid (result_valid),
		.dup_value    (dup_value),
		.occurrences  (occurrences),
		.found        (found),
		.last_report  (last_report)
	);

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for duplicate_value_counter_unit: directed and random value sets.
`default_nettype none
module tb_top
	import dvc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 100000;
	localparam int RANDOM_ITEMS  = 350;
	localparam int DRAIN_CYCLES  = MAX_ITEMS_DEF + 16;

	typedef struct packed {
		logic [VALUE_W-1:0] dup_value;
		logic [OCC_W-1:0]   occurrences;
		logic               found;
		logic               last_report;
	} dup_report_t;

	class dup_scoreboard;
		logic [VALUE_W-1:0] seq_store[MAX_ITEMS_DEF];
		logic [OCC_W-1:0]   hist[VALUE_RANGE_DEF];
		bit                 reported[VALUE_RANGE_DEF];
		int                 loaded;
		dup_report_t        report_q[$];
		int                 errors;
		int                 results_seen;
		int                 not_found_seen;
		int                 full_sets;

		function new();
			errors = 0;
			results_seen = 0;
			not_found_seen = 0;
			full_sets = 0;
			clear_set();
		endfunction

		function void clear_set();
			foreach (hist[i]) hist[i] = '0;
			foreach (reported[i]) reported[i] = 1'b0;
			loaded = 0;
		endfunction

		function int pending();
			return report_q.size();
		endfunction

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void note_input(input logic [VALUE_W-1:0] v, input logic fin);
			dup_report_t r;
			logic [VALUE_W-1:0] s;
			int n;
			n = 0;
			if (int'(v) < VALUE_RANGE_DEF && loaded < MAX_ITEMS_DEF) begin
				seq_store[loaded] = v;
				loaded++;
				hist[v] = hist[v] + 1'b1;
			end else begin
				full_sets += (fin && loaded == MAX_ITEMS_DEF) ? 1 : 0;
			end
			if (!fin)
				return;
			for (int k = 0; k < loaded; k++) begin
				s = seq_store[k];
				if (reported[s] || hist[s] <= 1)
					continue;
				reported[s] = 1'b1;
				r.dup_value = s;
				r.occurrences = hist[s];
				r.found = 1'b1;
				r.last_report = 1'b0;
				report_q.push_back(r);
				n++;
			end
			if (n == 0) begin
				r = '0;
				r.last_report = 1'b1;
				report_q.push_back(r);
			end else begin
				report_q[report_q.size() - 1].last_report = 1'b1;
			end
			clear_set();
		endfunction

		task check_result(input logic [VALUE_W-1:0] dv, input logic [OCC_W-1:0] occ,
				input logic f, input logic last);
			dup_report_t e;
			results_seen++;
			if (report_q.size() == 0) begin
				report($sformatf("unexpected result dup_value=%0d occurrences=%0d found=%b",
					dv, occ, f));
				return;
			end
			e = report_q.pop_front();
			if (!e.found)
				not_found_seen++;
			if (dv !== e.dup_value)
				report($sformatf("dup_value %0d, expected %0d", dv, e.dup_value));
			if (occ !== e.occurrences)
				report($sformatf("occurrences %0d, expected %0d (value %0d)",
					occ, e.occurrences, e.dup_value));
			if (f !== e.found)
				report($sformatf("found %b, expected %b", f, e.found));
			if (last !== e.last_report)
				report($sformatf("last_report %b, expected %b", last, e.last_report));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [VALUE_W-1:0] value = '0;
	logic               final_item = 1'b0;
	logic               busy;
	logic               result_valid;
	logic [VALUE_W-1:0] dup_value;
	logic [OCC_W-1:0]   occurrences;
	logic               found;
	logic               last_report;

	dup_scoreboard sb = new();
	int cycles = 0;
	int idle_pct = 0;
	int items_sent = 0;
	int sets_sent = 0;

	duplicate_value_counter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.final_item   (final_item),
		.result_valid (result_valid),
		.dup_value    (dup_value),
		.occurrences  (occurrences),
		.found        (found),
		.last_report  (last_report)
	);

	always begin
		#10;
		clk = 1'b1;
		#10;
		clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(dup_value, occurrences, found, last_report);
	end

	task automatic send_item(input logic [VALUE_W-1:0] v, input logic fin);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			value <= VALUE_W'($urandom);
			final_item <= 1'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		final_item <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_input(v, fin);
		items_sent++;
	endtask

	task automatic send_set(input logic [VALUE_W-1:0] vals[$]);
		foreach (vals[k])
			send_item(vals[k], k == vals.size() - 1);
		sets_sent++;
	endtask

	task automatic random_set();
		logic [VALUE_W-1:0] vals[$];
		logic [VALUE_W-1:0] tmp;
		int mode, len, base, alph, step, j;
		mode = $urandom_range(99);
		if (mode < 8) begin
			base = $urandom_range(127);
			step = 2 * $urandom_range(63) + 1;
			for (int k = 0; k < MAX_ITEMS_DEF; k++)
				vals.push_back(VALUE_W'(base + (k / 2) * step));
			for (int k = MAX_ITEMS_DEF - 1; k > 0; k--) begin
				j = $urandom_range(k);
				tmp = vals[k];
				vals[k] = vals[j];
				vals[j] = tmp;
			end
		end else if (mode < 14) begin
			len = $urandom_range(MAX_ITEMS_DEF + 8, MAX_ITEMS_DEF + 1);
			alph = $urandom_range(40, 2);
			base = $urandom_range(127);
			for (int k = 0; k < len; k++)
				vals.push_back(VALUE_W'(base + $urandom_range(alph - 1)));
		end else if (mode < 19) begin
			len = $urandom_range(MAX_ITEMS_DEF, 2);
			base = $urandom_range(127);
			for (int k = 0; k < len; k++)
				vals.push_back(VALUE_W'(base));
		end else if (mode < 32) begin
			len = $urandom_range(20, 1);
			base = $urandom_range(127);
			step = 2 * $urandom_range(63) + 1;
			for (int k = 0; k < len; k++)
				vals.push_back(VALUE_W'(base + k * step));
		end else if (mode < 40) begin
			len = $urandom_range(24, 1);
			for (int k = 0; k < len; k++)
				vals.push_back(VALUE_W'($urandom_range(127)));
		end else begin
			len = $urandom_range(24, 2);
			alph = $urandom_range(8, 2);
			base = $urandom_range(127);
			for (int k = 0; k < len; k++)
				vals.push_back(VALUE_W'(base + $urandom_range(alph - 1)));
		end
		send_set(vals);
	endtask

	initial begin
		int random_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		idle_pct = 0;
		send_set('{7'd5});
		send_set('{7'd0, 7'd127, 7'd0, 7'd127, 7'd127});
		send_set('{7'd85, 7'd42, 7'd85, 7'd42});
		send_set('{7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd64});
		send_set('{7'd9, 7'd9});

		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (items_sent - random_start < RANDOM_ITEMS / 3)
				idle_pct = 28;
			else if (items_sent - random_start < 2 * RANDOM_ITEMS / 3)
				idle_pct = 64;
			else
				idle_pct = 0;
			random_set();
		end
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d sets, %0d values, %0d overfilled sets, in %0d cycles",
			sets_sent, items_sent, sb.full_sets, cycles);
		$display("checked %0d results, %0d of them with no repeat, %0d mismatches",
			sb.results_seen, sb.not_found_seen, sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
hdl/dvc_pkg.sv
hdl/dvc_ram.sv
hdl/dvc_ctrl.sv
hdl/dvc_datapath.sv
hdl/duplicate_value_counter_unit.sv
verif/tb_top.sv
